### rtl/umsr_pkg.sv
// shared types, constants and helpers for the ultrasonic ranger
`default_nettype none

package umsr_pkg;

  // sensor and timer sizing
  localparam int NUM_SENSORS = 8;
  localparam int SENS_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int TIMER_BITS  = 20;
  localparam int CNT_W       = $clog2(TIMER_BITS + 1);

  // fixed field widths
  localparam int MASK_W  = 8;
  localparam int CFG_W   = 20;
  localparam int SHORT_W = 8;
  localparam int DIST_W  = 16;
  localparam int SIDX_W  = 3;
  localparam int IDX_W   = 3;
  localparam int CMP_W   = TIMER_BITS + CFG_W;

  // input queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic [TIMER_BITS-1:0] timer_t;

  localparam timer_t CNT_MAX = {TIMER_BITS{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // register reset values
  localparam logic [MASK_W-1:0]  RST_ACTIVE_MASK  = '0;
  localparam logic [CFG_W-1:0]   RST_MAX_ECHO     = CFG_W'(30000);
  localparam logic [SHORT_W-1:0] RST_TICKS_PER_CM = SHORT_W'(58);
  localparam logic [CFG_W-1:0]   RST_PAUSE        = '0;
  localparam logic [CFG_W-1:0]   RST_IDLE_CHECK   = CFG_W'(25000);
  localparam logic [SHORT_W-1:0] RST_TRIGGER      = SHORT_W'(10);

  // ranging phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_TRIG,
    PH_RISE,
    PH_HIGH
  } phase_t;

  // back end sequencer
  typedef enum logic {
    EX_READY,
    EX_DIV
  } exec_t;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ACTIVE_MASK  = 3'd0,
    REG_MAX_ECHO     = 3'd1,
    REG_TICKS_PER_CM = 3'd2,
    REG_PAUSE        = 3'd3,
    REG_IDLE_CHECK   = 3'd4,
    REG_TRIGGER      = 3'd5
  } reg_idx_t;

  // one result beat
  typedef struct packed {
    logic [MASK_W-1:0] trigger_mask;
    logic              valid;
    logic [SIDX_W-1:0] sensor;
    logic [DIST_W-1:0] distance;
    logic              timeout;
    logic              busy;
  } result_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    timer_t             dividend;
    logic [SHORT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    timer_t quotient;
  } div_rsp_t;

  // load a wait value into the timer, saturated to its maximum
  function automatic timer_t sat_load(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(v);
    if (wide > CMP_W'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return timer_t'(wide);
  endfunction

endpackage

`default_nettype wire

### rtl/ultrasonic_multi_sensor_ranger_core.sv
// Round-robin ultrasonic ranger: one echo beat in, one result beat out per tick.
// Each echo beat passes through the input queue and is registered into the output slot; a tick
// that ends a good echo first waits for a TIMER_BITS-step divider that forms the distance.
// The single output slot must be popped before the next tick steps, and a tick that needs
// the divider holds the next tick off until the quotient is done.
// Reset (rst, synchronous): queues empty, registers at defaults, ranging idle.
`default_nettype none

module ultrasonic_multi_sensor_ranger_core
  import umsr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [MASK_W-1:0]  echo_levels,
  output logic                    empty,
  input  wire logic               pop,
  output logic [MASK_W-1:0]       trigger_mask,
  output logic                    result_valid,
  output logic [SIDX_W-1:0]       result_sensor,
  output logic [DIST_W-1:0]       result_distance,
  output logic                    result_timeout,
  output logic                    busy_res
);

  logic              q_valid;
  logic [MASK_W-1:0] q_data;
  logic              q_pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  result_t           out_res;

  // input queue
  umsr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .echo_levels (echo_levels),
    .full        (full),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop)
  );

  // distance divider
  umsr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ranging sequencer
  umsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .pop       (pop),
    .empty     (empty),
    .out_res   (out_res)
  );

  // result fields
  assign trigger_mask    = out_res.trigger_mask;
  assign result_valid    = out_res.valid;
  assign result_sensor   = out_res.sensor;
  assign result_distance = out_res.distance;
  assign result_timeout  = out_res.timeout;
  assign busy_res        = out_res.busy;

endmodule

`default_nettype wire

### rtl/umsr_front.sv
// input queue: accepts echo beats and holds them for the back end
`default_nettype none

module umsr_front
  import umsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [MASK_W-1:0] echo_levels,
  output logic                   full,
  output logic                   q_valid,
  output logic [MASK_W-1:0]      q_data,
  input  wire logic              q_pop
);

  logic [MASK_W-1:0] mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  // handshake
  assign full    = (count == (QPTR_W + 1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign q_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= echo_levels;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/umsr_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module umsr_div
  import umsr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  timer_t             quo;
  logic [SHORT_W-1:0] rem;
  logic [SHORT_W-1:0] divisor;
  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic               done;
  logic [SHORT_W:0]   rem_sh;
  logic               fits;

  // one restoring step
  assign rem_sh = {rem, quo[TIMER_BITS-1]};
  assign fits   = (rem_sh >= {1'b0, divisor});

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (running) begin
      quo <= {quo[TIMER_BITS-2:0], fits};
      rem <= fits ? SHORT_W'(rem_sh - {1'b0, divisor}) : SHORT_W'(rem_sh);
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(TIMER_BITS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

### rtl/umsr_back.sv
// ranging sequencer: steps one tick per beat, divides and holds the result
`default_nettype none

module umsr_back
  import umsr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               q_valid,
  input  wire logic [MASK_W-1:0]  q_data,
  output logic                    q_pop,
  output div_req_t                div_req,
  input  wire div_rsp_t           div_rsp,
  input  wire logic               pop,
  output logic                    empty,
  output result_t                 out_res
);

  // configuration
  logic [MASK_W-1:0]  active_mask;
  logic [CFG_W-1:0]   max_echo_us;
  logic [SHORT_W-1:0] ticks_per_cm;
  logic [CFG_W-1:0]   pause_us;
  logic [CFG_W-1:0]   idle_check_us;
  logic [SHORT_W-1:0] trigger_us;

  // ranging state
  phase_t             phase;
  logic [SENS_W-1:0]  current_sensor;
  timer_t             interval_counter;
  logic [SHORT_W-1:0] pulse_counter;
  logic [MASK_W-1:0]  previous_echo;

  // sequencer and output slot
  exec_t   ex;
  exec_t   ex_next;
  logic    out_full;
  result_t pend;
  result_t div_res;

  // step results
  phase_t             phase_next;
  logic [SENS_W-1:0]  current_sensor_next;
  timer_t             interval_counter_next;
  logic [SHORT_W-1:0] pulse_counter_next;
  result_t            step_res;
  logic               need_div;
  logic               do_scan;
  logic               step_fire;
  logic               out_load;
  logic               div_start;

  // helpers
  logic [MASK_W-1:0]  ready_vec;
  logic               scan_found;
  logic [SENS_W-1:0]  scan_idx;
  logic               cur_echo;
  logic               prev_echo_bit;
  timer_t             cnt_inc;
  logic               cnt_hit;
  logic [SHORT_W-1:0] trig_len;
  timer_t             idle_load;
  logic               cfg_drop;

  assign cur_echo      = q_data[current_sensor];
  assign prev_echo_bit = previous_echo[current_sensor];
  assign cnt_inc       = (interval_counter != CNT_MAX) ? interval_counter + 1'b1 : CNT_MAX;
  assign cnt_hit       = (CMP_W'(cnt_inc) >= CMP_W'(max_echo_us));
  assign trig_len      = (trigger_us == '0) ? SHORT_W'(1) : trigger_us;
  assign idle_load     = sat_load((idle_check_us == '0) ? CFG_W'(1) : idle_check_us);
  assign ready_vec     = active_mask & ~q_data;

  // round-robin search from the sensor after the current one
  always_comb begin
    logic [SENS_W:0] pos;
    scan_found = 1'b0;
    scan_idx   = '0;
    for (int k = NUM_SENSORS; k >= 1; k--) begin
      pos = (SENS_W + 1)'(current_sensor) + (SENS_W + 1)'(k);
      if (pos >= (SENS_W + 1)'(NUM_SENSORS)) begin
        pos = pos - (SENS_W + 1)'(NUM_SENSORS);
      end
      if (ready_vec[SENS_W'(pos)]) begin
        scan_found = 1'b1;
        scan_idx   = SENS_W'(pos);
      end
    end
  end

  // one tick of the ranging phase machine
  always_comb begin
    phase_next            = phase;
    current_sensor_next   = current_sensor;
    interval_counter_next = interval_counter;
    pulse_counter_next    = pulse_counter;
    step_res              = '0;
    need_div              = 1'b0;
    do_scan               = 1'b0;

    unique case (phase)
      PH_WAIT: begin
        if (interval_counter > timer_t'(1)) begin
          interval_counter_next = interval_counter - 1'b1;
        end else begin
          do_scan = 1'b1;
        end
      end
      PH_TRIG: begin
        if (pulse_counter < trig_len) begin
          pulse_counter_next    = pulse_counter + 1'b1;
          step_res.trigger_mask = MASK_W'(1) << current_sensor;
        end else begin
          phase_next            = PH_RISE;
          interval_counter_next = '0;
        end
      end
      PH_RISE: begin
        interval_counter_next = cnt_inc;
        if (cur_echo && !prev_echo_bit) begin
          phase_next            = PH_HIGH;
          interval_counter_next = '0;
        end else if (cnt_hit) begin
          step_res.valid   = 1'b1;
          step_res.sensor  = SIDX_W'(current_sensor);
          step_res.timeout = 1'b1;
          do_scan          = 1'b1;
        end
      end
      PH_HIGH: begin
        interval_counter_next = cnt_inc;
        if (!cur_echo && prev_echo_bit) begin
          step_res.valid  = 1'b1;
          step_res.sensor = SIDX_W'(current_sensor);
          if (ticks_per_cm == '0) begin
            step_res.distance = DIST_MAX;
          end else begin
            need_div = 1'b1;
          end
          if (pause_us != '0) begin
            phase_next            = PH_WAIT;
            interval_counter_next = sat_load(pause_us);
          end else begin
            do_scan = 1'b1;
          end
        end else if (cnt_hit) begin
          step_res.valid   = 1'b1;
          step_res.sensor  = SIDX_W'(current_sensor);
          step_res.timeout = 1'b1;
          do_scan          = 1'b1;
        end
      end
      default: begin
        do_scan = 1'b1;
      end
    endcase

    // start the next sensor or fall back to the idle-check wait
    if (do_scan) begin
      if (scan_found) begin
        current_sensor_next   = scan_idx;
        phase_next            = PH_TRIG;
        pulse_counter_next    = SHORT_W'(1);
        step_res.trigger_mask = MASK_W'(1) << scan_idx;
      end else begin
        phase_next            = PH_WAIT;
        interval_counter_next = idle_load;
      end
    end

    step_res.busy = (phase_next == PH_TRIG) || (phase_next == PH_RISE) ||
                    (phase_next == PH_HIGH);
  end

  // sequencer next state
  always_comb begin
    ex_next = ex;
    unique case (ex)
      EX_READY: begin
        if (step_fire && need_div) begin
          ex_next = EX_DIV;
        end
      end
      EX_DIV: begin
        if (div_rsp.done) begin
          ex_next = EX_READY;
        end
      end
      default: ex_next = EX_READY;
    endcase
  end

  // sequencer outputs
  always_comb begin
    step_fire = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    unique case (ex)
      EX_READY: begin
        step_fire = q_valid && !out_full;
        out_load  = step_fire && !need_div;
        div_start = step_fire && need_div;
      end
      EX_DIV: begin
        out_load = div_rsp.done;
      end
      default: ;
    endcase
  end

  assign q_pop            = step_fire;
  assign div_req.start    = div_start;
  assign div_req.dividend = cnt_inc;
  assign div_req.divisor  = ticks_per_cm;
  assign empty            = !out_full;

  // current sensor drops out of the mask while ranging
  assign cfg_drop = !cfg_data[current_sensor] &&
                    ((phase == PH_TRIG) || (phase == PH_RISE) || (phase == PH_HIGH));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask   <= RST_ACTIVE_MASK;
      max_echo_us   <= RST_MAX_ECHO;
      ticks_per_cm  <= RST_TICKS_PER_CM;
      pause_us      <= RST_PAUSE;
      idle_check_us <= RST_IDLE_CHECK;
      trigger_us    <= RST_TRIGGER;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACTIVE_MASK:  active_mask   <= MASK_W'(cfg_data);
        REG_MAX_ECHO:     max_echo_us   <= cfg_data;
        REG_TICKS_PER_CM: ticks_per_cm  <= SHORT_W'(cfg_data);
        REG_PAUSE:        pause_us      <= cfg_data;
        REG_IDLE_CHECK:   idle_check_us <= cfg_data;
        REG_TRIGGER:      trigger_us    <= SHORT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // ranging state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      current_sensor   <= SENS_W'(NUM_SENSORS - 1);
      interval_counter <= '0;
      pulse_counter    <= '0;
      previous_echo    <= '0;
    end else if (cfg_write && (cfg_index == REG_ACTIVE_MASK)) begin
      if (cfg_drop) begin
        phase            <= PH_WAIT;
        interval_counter <= idle_load;
      end
    end else if (step_fire) begin
      phase            <= phase_next;
      current_sensor   <= current_sensor_next;
      interval_counter <= interval_counter_next;
      pulse_counter    <= pulse_counter_next;
      previous_echo    <= q_data;
    end
  end

  // sequencer state and output slot control
  always_ff @(posedge clk) begin
    if (rst) begin
      ex       <= EX_READY;
      out_full <= 1'b0;
    end else begin
      ex <= ex_next;
      if (out_load) begin
        out_full <= 1'b1;
      end else if (pop && out_full) begin
        out_full <= 1'b0;
      end
    end
  end

  // result held while the quotient is worked out
  always_ff @(posedge clk) begin
    if (div_start) begin
      pend <= step_res;
    end
  end

  // held result with the saturated quotient as distance
  always_comb begin
    div_res          = pend;
    div_res.distance = (div_rsp.quotient > timer_t'(DIST_MAX)) ?
                       DIST_MAX : DIST_W'(div_rsp.quotient);
  end

  // output slot payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (ex == EX_DIV) begin
        out_res <= div_res;
      end else begin
        out_res <= step_res;
      end
    end
  end

endmodule

`default_nettype wire

### tb/ranging_checker.sv
`timescale 1ns / 1ps
// checker for the ranger core: predicts each result beat and compares it with the block
module ranging_checker
  import umsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              push,
  input  logic              full,
  input  logic [MASK_W-1:0] echo_levels,
  input  logic              empty,
  input  logic              pop,
  input  logic [MASK_W-1:0] trigger_mask,
  input  logic              result_valid,
  input  logic [SIDX_W-1:0] result_sensor,
  input  logic [DIST_W-1:0] result_distance,
  input  logic              result_timeout,
  input  logic              busy_res,
  output int                pending,
  output int                errors
);

  localparam int MAX_SHOWN = 10;

  // register copies
  logic [MASK_W-1:0]  mask_r;
  logic [CFG_W-1:0]   max_echo_r;
  logic [SHORT_W-1:0] cm_div_r;
  logic [CFG_W-1:0]   pause_r;
  logic [CFG_W-1:0]   idle_r;
  logic [SHORT_W-1:0] trig_len_r;

  // ranging state
  phase_t             ph;
  logic [SENS_W-1:0]  cur_sensor;
  timer_t             tick_count;
  logic [SHORT_W-1:0] trig_ticks;
  logic [MASK_W-1:0]  last_echo;

  result_t due_results[$];
  result_t seen_beat;
  result_t due_beat;
  int      beat_no;

  // no sensor ready or current one dropped: retry later
  function automatic void begin_idle_wait();
    ph = PH_WAIT;
    tick_count = (idle_r == '0) ? timer_t'(1) : timer_t'(idle_r);
  endfunction

  // round-robin search for an active sensor with a low echo, returns trigger drive
  function automatic logic [MASK_W-1:0] pick_sensor(input logic [MASK_W-1:0] lv);
    logic [SENS_W-1:0] idx;
    for (int k = 1; k <= NUM_SENSORS; k++) begin
      idx = SENS_W'((cur_sensor + k) % NUM_SENSORS);
      if (mask_r[idx] && !lv[idx]) begin
        cur_sensor = idx;
        ph = PH_TRIG;
        trig_ticks = SHORT_W'(1);
        return MASK_W'(1) << idx;
      end
    end
    begin_idle_wait();
    return '0;
  endfunction

  // measurement ended by the range timeout
  function automatic result_t end_by_timeout(input logic [MASK_W-1:0] lv);
    result_t r;
    r = '0;
    r.valid = 1'b1;
    r.sensor = cur_sensor;
    r.timeout = 1'b1;
    r.trigger_mask = pick_sensor(lv);
    return r;
  endfunction

  // one echo tick in, one expected result beat out
  function automatic result_t range_tick(input logic [MASK_W-1:0] lv);
    result_t r;
    logic now_hi;
    logic was_hi;
    timer_t q;
    r = '0;
    now_hi = lv[cur_sensor];
    was_hi = last_echo[cur_sensor];
    case (ph)
      PH_WAIT: begin
        if (tick_count > timer_t'(1)) begin
          tick_count = tick_count - 1'b1;
        end else begin
          r.trigger_mask = pick_sensor(lv);
        end
      end
      PH_TRIG: begin
        if (trig_ticks < ((trig_len_r == '0) ? SHORT_W'(1) : trig_len_r)) begin
          trig_ticks = trig_ticks + 1'b1;
          r.trigger_mask = MASK_W'(1) << cur_sensor;
        end else begin
          ph = PH_RISE;
          tick_count = '0;
        end
      end
      PH_RISE: begin
        if (tick_count < CNT_MAX) tick_count = tick_count + 1'b1;
        if (now_hi && !was_hi) begin
          ph = PH_HIGH;
          tick_count = '0;
        end else if (tick_count >= max_echo_r) begin
          r = end_by_timeout(lv);
        end
      end
      PH_HIGH: begin
        if (tick_count < CNT_MAX) tick_count = tick_count + 1'b1;
        if (!now_hi && was_hi) begin
          if (cm_div_r == '0) q = timer_t'(DIST_MAX);
          else q = tick_count / cm_div_r;
          r.valid = 1'b1;
          r.sensor = cur_sensor;
          r.distance = (q > timer_t'(DIST_MAX)) ? DIST_MAX : q[DIST_W-1:0];
          if (pause_r != '0) begin
            ph = PH_WAIT;
            tick_count = timer_t'(pause_r);
          end else begin
            r.trigger_mask = pick_sensor(lv);
          end
        end else if (tick_count >= max_echo_r) begin
          r = end_by_timeout(lv);
        end
      end
      default: begin
        r.trigger_mask = pick_sensor(lv);
      end
    endcase
    last_echo = lv;
    r.busy = (ph == PH_TRIG) || (ph == PH_RISE) || (ph == PH_HIGH);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mask_r = RST_ACTIVE_MASK;
      max_echo_r = RST_MAX_ECHO;
      cm_div_r = RST_TICKS_PER_CM;
      pause_r = RST_PAUSE;
      idle_r = RST_IDLE_CHECK;
      trig_len_r = RST_TRIGGER;
      ph = PH_IDLE;
      cur_sensor = SENS_W'(NUM_SENSORS - 1);
      tick_count = '0;
      trig_ticks = '0;
      last_echo = '0;
      due_results.delete();
    end else begin
      // register writes, only seen while no beat is in flight
      if (cfg_write) begin
        case (cfg_index)
          REG_ACTIVE_MASK: begin
            mask_r = cfg_data[MASK_W-1:0];
            if ((ph == PH_TRIG || ph == PH_RISE || ph == PH_HIGH) && !mask_r[cur_sensor])
              begin_idle_wait();
          end
          REG_MAX_ECHO:     max_echo_r = cfg_data;
          REG_TICKS_PER_CM: cm_div_r = cfg_data[SHORT_W-1:0];
          REG_PAUSE:        pause_r = cfg_data;
          REG_IDLE_CHECK:   idle_r = cfg_data;
          REG_TRIGGER:      trig_len_r = cfg_data[SHORT_W-1:0];
          default: ;
        endcase
      end

      // result beat against the oldest expectation
      if (pop && !empty) begin
        seen_beat.trigger_mask = trigger_mask;
        seen_beat.valid = result_valid;
        seen_beat.sensor = result_sensor;
        seen_beat.distance = result_distance;
        seen_beat.timeout = result_timeout;
        seen_beat.busy = busy_res;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("result beat %0d arrived with nothing expected", beat_no);
        end else begin
          due_beat = due_results.pop_front();
          if (seen_beat != due_beat) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("beat %0d: expected trig=%h valid=%b sensor=%0d dist=%0d tmo=%b busy=%b",
                       beat_no, due_beat.trigger_mask, due_beat.valid, due_beat.sensor,
                       due_beat.distance, due_beat.timeout, due_beat.busy,
                       " / got trig=%h valid=%b sensor=%0d dist=%0d tmo=%b busy=%b",
                       seen_beat.trigger_mask, seen_beat.valid, seen_beat.sensor,
                       seen_beat.distance, seen_beat.timeout, seen_beat.busy);
          end
        end
        beat_no++;
      end

      // echo beat accepted: predict its result
      if (push && !full) due_results.push_back(range_tick(echo_levels));
    end
    pending <= due_results.size();
  end

endmodule

### tb/ultrasonic_multi_sensor_ranger_core_tb.sv
`timescale 1ns / 1ps
// testbench top for the ranger core: clock, reset, echo stimulus, register setup and verdict
module ultrasonic_multi_sensor_ranger_core_tb;
  import umsr_pkg::*;

  localparam int RUN_LIMIT     = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 90;
  // indexes past the register list, writes there are ignored
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              push;
  logic              full;
  logic [MASK_W-1:0] echo_levels;
  logic              empty;
  logic              pop;
  logic [MASK_W-1:0] trigger_mask;
  logic              result_valid;
  logic [SIDX_W-1:0] result_sensor;
  logic [DIST_W-1:0] result_distance;
  logic              result_timeout;
  logic              busy_res;
  int                pending;
  int                errors;

  bit          steady;
  int          hold_asks;
  int          hold_seen;
  int          hold_left;
  int          cycle_count;
  logic        lvl [NUM_SENSORS];
  int unsigned run_len [NUM_SENSORS];

  ultrasonic_multi_sensor_ranger_core DUT (.*);

  ranging_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls, a long hold-off on request
  initial begin
    pop = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  // offer one echo beat, with random gaps, until it is taken
  task automatic send_tick(input logic [MASK_W-1:0] lv);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 17) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    echo_levels <= lv;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // stop offering and wait for every expected beat plus the block's latency
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // full register set, junk in the unused upper bits of the short registers
  task automatic set_ranger(input logic [MASK_W-1:0] mask, input logic [CFG_W-1:0] max_echo,
                            input logic [SHORT_W-1:0] per_cm, input logic [CFG_W-1:0] pause,
                            input logic [CFG_W-1:0] idle_check,
                            input logic [SHORT_W-1:0] trig_len);
    put_reg(REG_ACTIVE_MASK, {12'($urandom), mask});
    put_reg(REG_MAX_ECHO, max_echo);
    put_reg(REG_TICKS_PER_CM, {12'($urandom), per_cm});
    put_reg(REG_PAUSE, pause);
    put_reg(REG_IDLE_CHECK, idle_check);
    put_reg(REG_TRIGGER, {12'($urandom), trig_len});
  endtask

  // per-sensor echo pulse trains, some stuck high, with some raw noise beats
  task automatic run_ticks(input int count, input int unsigned high_max);
    logic [MASK_W-1:0] lv;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 12) begin
        lv = MASK_W'($urandom);
      end else begin
        for (int s = 0; s < NUM_SENSORS; s++) begin
          if (run_len[s] == 0) begin
            lvl[s] = ~lvl[s];
            if (lvl[s])
              run_len[s] = ($urandom_range(99) < 4) ? 4 * high_max : $urandom_range(1, high_max);
            else
              run_len[s] = $urandom_range(1, 12);
          end
          run_len[s]--;
          lv[s] = lvl[s];
        end
      end
      send_tick(lv);
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    echo_levels = '0;
    steady = 1'b0;
    hold_asks = 0;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      lvl[s] = 1'b0;
      run_len[s] = $urandom_range(1, 8);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sensor 0 only, default trigger and timeout: full trigger, short echo, distance
    put_reg(REG_ACTIVE_MASK, {12'hFFF, 8'h01});
    put_reg(REG_TICKS_PER_CM, 20'd2);
    repeat (11) send_tick(8'h00);
    repeat (5) send_tick(8'h01);
    send_tick(8'h00);
    settle();

    // zero registers: one-tick trigger, instant timeouts, saturated distance
    set_ranger(8'hFF, 20'd0, 8'd0, 20'd0, 20'd0, 8'd0);
    put_reg(REG_SPARE_A, 20'hFFFFF);
    put_reg(REG_SPARE_B, 20'($urandom));
    send_tick(8'h00);
    send_tick(8'h01);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'h08);
    send_tick(8'h08);
    settle();

    // current sensor dropped from the mask while its trigger runs
    set_ranger(8'h02, 20'd50, 8'd1, 20'd0, 20'd1, 8'd3);
    send_tick(8'h00);
    send_tick(8'h00);
    settle();
    put_reg(REG_ACTIVE_MASK, 20'h00004);
    send_tick(8'h00);
    send_tick(8'h00);
    settle();

    // all sensors, short pulses, a stretch without stalls, then a full drain
    set_ranger(8'hFF, 20'd200, 8'd3, 20'd0, 20'd4, 8'd2);
    run_ticks(60, 40);
    steady = 1'b1;
    run_ticks(60, 40);
    steady = 1'b0;
    settle();
    run_ticks(60, 40);
    settle();

    // frequent timeouts and pauses, result side held off to fill the block
    set_ranger(8'h5A, 20'd30, 8'd1, 20'd5, 20'd3, 8'd1);
    hold_asks++;
    run_ticks(120, 50);
    settle();

    // longest timeout and largest divisor with long echoes
    set_ranger(8'hC3, 20'd1000000, 8'd255, 20'd0, 20'd1, 8'd1);
    run_ticks(120, 700);
    settle();

    // longest trigger, pause and retry, shortest timeout
    set_ranger(8'hFF, 20'd1, 8'd1, 20'd1000000, 20'd1000000, 8'd255);
    run_ticks(60, 20);
    settle();

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### ultrasonic_multi_sensor_ranger_core.f
rtl/umsr_pkg.sv
rtl/umsr_front.sv
rtl/umsr_div.sv
rtl/umsr_back.sv
rtl/ultrasonic_multi_sensor_ranger_core.sv
tb/ranging_checker.sv
tb/ultrasonic_multi_sensor_ranger_core_tb.sv
